@@ rtl/core/pvd_pkg.sv @@
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared types, constants and table functions of the 4-bit ADPCM block decoder.
// ----------------------------------------------------------------------------
package pvd_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int CH_W         = 3;
	localparam int CTX_IDX_W    = 4;
	localparam int SAMPLE_W     = 16;

	localparam logic [3:0] SHIFT_MAX    = 4'd12;
	localparam logic [3:0] SHIFT_SUBST  = 4'd9;
	localparam logic [3:0] FILTER_MAX   = 4'd4;
	localparam logic [3:0] POS_HEADER   = 4'd0;
	localparam logic [3:0] POS_FLAGS    = 4'd1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic [3:0] pos;
		logic [3:0] shift;
		logic [2:0] filter;
		sample_t    hist1;
		sample_t    hist2;
	} ctx_rec_t;

	typedef struct packed {
		logic                 en;
		logic [CTX_IDX_W-1:0] idx;
		ctx_rec_t             rec;
	} ctx_wr_t;

	function automatic logic signed [7:0] coef_new(input logic [2:0] f);
		logic signed [7:0] c;
		unique case (f)
			3'd1:    c = 8'sd60;
			3'd2:    c = 8'sd115;
			3'd3:    c = 8'sd98;
			3'd4:    c = 8'sd122;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [7:0] coef_old(input logic [2:0] f);
		logic signed [7:0] c;
		unique case (f)
			3'd2:    c = -8'sd52;
			3'd3:    c = -8'sd55;
			3'd4:    c = -8'sd60;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] hdr_shift(input logic [3:0] nib);
		return (nib > SHIFT_MAX) ? SHIFT_SUBST : nib;
	endfunction

	function automatic logic [2:0] hdr_filter(input logic [3:0] nib);
		return (nib > FILTER_MAX) ? 3'd0 : nib[2:0];
	endfunction

endpackage

@@ rtl/core/pvd_predict.sv @@
// ----------------------------------------------------------------------------
// pvd_predict
// Turns one nibble into a PCM sample from the block's shift and filter and
// the two previous samples of the channel, with saturation to 16 bits.
// ----------------------------------------------------------------------------
module pvd_predict (
	input  logic [3:0]       nibble,
	input  logic [3:0]       shift,
	input  logic [2:0]       filter,
	input  pvd_pkg::sample_t hist1,
	input  pvd_pkg::sample_t hist2,
	output pvd_pkg::sample_t sample
);

	logic [3:0]        sh_eff;
	logic [2:0]        f_eff;
	logic signed [3:0] nib_s;
	logic signed [16:0] scaled;
	logic signed [7:0] c_new;
	logic signed [7:0] c_old;
	logic signed [24:0] acc;
	logic signed [18:0] pred;
	logic signed [19:0] sum;

	always_comb begin
		sh_eff = (shift > pvd_pkg::SHIFT_MAX) ? pvd_pkg::SHIFT_MAX : shift;
		f_eff  = ({1'b0, filter} > pvd_pkg::FILTER_MAX) ? 3'd0 : filter;
		nib_s  = nibble;
		scaled = 17'(nib_s) <<< (pvd_pkg::SHIFT_MAX - sh_eff);
		c_new  = pvd_pkg::coef_new(f_eff);
		c_old  = pvd_pkg::coef_old(f_eff);
		acc    = 25'(hist1) * 25'(c_new) + 25'(hist2) * 25'(c_old) + 25'sd32;
		pred   = acc[24:6];
		sum    = 20'(scaled) + 20'(pred);
		if (sum > 20'sd32767) begin
			sample = 16'sh7FFF;
		end else if (sum < -20'sd32768) begin
			sample = 16'sh8000;
		end else begin
			sample = sum[15:0];
		end
	end

endmodule

@@ rtl/core/pvd_ctx.sv @@
// ----------------------------------------------------------------------------
// pvd_ctx
// Per-channel decoder context: block position, shift, filter and the two
// most recent samples. One read port and one write port.
// ----------------------------------------------------------------------------
module pvd_ctx #(
	parameter int CHANNELS = pvd_pkg::CHANNELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [pvd_pkg::CTX_IDX_W-1:0]    rd_idx,
	output pvd_pkg::ctx_rec_t                rd_rec,
	input  pvd_pkg::ctx_wr_t                 wr
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	pvd_pkg::ctx_rec_t ctx_q [CHANNELS];

	assign rd_rec = ctx_q[rd_idx[IDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				ctx_q[i] <= '0;
			end
		end else if (wr.en) begin
			ctx_q[wr.idx[IDX_W-1:0]] <= wr.rec;
		end
	end

endmodule

@@ rtl/core/ps_adpcm_vag_decoder_unit.sv @@
// A data byte waits in the input stage register; its first, then its second sample
// pass through the shared predictor into the output register, and a stalled output
// holds either back. Header, flags and absent-channel bytes give no sample and do not
// wait on the output. A new byte is accepted as the previous one is consumed.
// Reset clears every channel's history, block position, shift and filter at once.
// ----------------------------------------------------------------------------
// ps_adpcm_vag_decoder_unit
// Multi-channel 4-bit ADPCM block decoder: one byte in, up to two samples out.
// ----------------------------------------------------------------------------
module ps_adpcm_vag_decoder_unit #(
	parameter int CHANNELS = pvd_pkg::CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // channel[2:0], in_byte[10:3], zeros
	input  logic        s_axis_tuser,   // restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // out_channel[2:0], sample[18:3], zeros
	output logic        m_axis_tlast
);

	logic                       v_s1;
	logic [pvd_pkg::CH_W-1:0]   ch_s1;
	logic [7:0]                 byte_s1;
	logic                       rst_s1;
	logic                       ph_q;

	logic                       o_valid_q;
	logic [pvd_pkg::CH_W-1:0]   o_ch_q;
	pvd_pkg::sample_t           o_sample_q;
	logic                       o_last_q;

	logic [pvd_pkg::CTX_IDX_W-1:0] idx;
	pvd_pkg::ctx_rec_t          rd_rec;
	pvd_pkg::ctx_rec_t          cur;
	pvd_pkg::ctx_wr_t           wr;
	pvd_pkg::sample_t           smp;
	logic                       ch_ok;
	logic                       cleared;
	logic                       is_data;
	logic                       out_free;
	logic                       step;
	logic                       consume;
	logic                       in_acc;
	logic [3:0]                 nibble;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign idx      = pvd_pkg::CTX_IDX_W'(ch_s1);
	assign ch_ok    = 5'(ch_s1) < 5'(CHANNELS);
	assign cleared  = rst_s1 && !ph_q;
	assign cur      = cleared ? '0 : rd_rec;
	assign is_data  = ph_q || ((cur.pos != pvd_pkg::POS_HEADER) &&
	                           (cur.pos != pvd_pkg::POS_FLAGS));
	assign out_free = !o_valid_q || m_axis_tready;
	assign step     = v_s1 && ch_ok && is_data && out_free;
	assign consume  = v_s1 && (!ch_ok || !is_data || (ph_q && out_free));
	assign nibble   = ph_q ? byte_s1[7:4] : byte_s1[3:0];

	assign s_axis_tready = !v_s1 || consume;

	pvd_ctx #(
		.CHANNELS(CHANNELS)
	) u_ctx (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (idx),
		.rd_rec (rd_rec),
		.wr     (wr)
	);

	pvd_predict u_predict (
		.nibble (nibble),
		.shift  (cur.shift),
		.filter (cur.filter),
		.hist1  (cur.hist1),
		.hist2  (cur.hist2),
		.sample (smp)
	);

	always_comb begin
		wr.en  = v_s1 && ch_ok && (!is_data || out_free);
		wr.idx = idx;
		wr.rec = cur;
		if (!is_data) begin
			wr.rec.pos = cur.pos + 4'd1;
			if (cur.pos == pvd_pkg::POS_HEADER) begin
				wr.rec.shift  = pvd_pkg::hdr_shift(byte_s1[3:0]);
				wr.rec.filter = pvd_pkg::hdr_filter(byte_s1[7:4]);
			end
		end else begin
			wr.rec.hist2 = cur.hist1;
			wr.rec.hist1 = smp;
			if (!ph_q) begin
				wr.rec.pos = cur.pos + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			ph_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (consume) begin
				v_s1 <= 1'b0;
			end
			if (consume) begin
				ph_q <= 1'b0;
			end else if (step) begin
				ph_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_s1   <= s_axis_tdata[2:0];
			byte_s1 <= s_axis_tdata[10:3];
			rst_s1  <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (step) begin
			o_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			o_ch_q     <= ch_s1;
			o_sample_q <= smp;
			o_last_q   <= ph_q;
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata  = {5'd0, o_sample_q, o_ch_q};
	assign m_axis_tlast  = o_last_q;

endmodule

@@ rtl/core/pvd_checker.sv @@
// ----------------------------------------------------------------------------
// pvd_checker
// Port-level checks of the decoder's output ordering and stall behaviour.
// ----------------------------------------------------------------------------
module pvd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// A stalled output transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output payload changed while stalled");

	// The second sample of a byte follows its first at once, on the same channel.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tvalid && m_axis_tlast &&
			(m_axis_tdata[2:0] == $past(m_axis_tdata[2:0])))
		else $error("second sample of a byte missing or on another channel");

	// An empty output register is always refilled with a first sample.
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !m_axis_tlast)
		else $error("second sample without its first");

	// When the input waits on an empty output, a sample appears in the next cycle.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid)
		else $error("input stalled with no sample on its way");

endmodule

bind ps_adpcm_vag_decoder_unit pvd_checker u_pvd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
